// ----- sv/sgb_pkg.sv -----
// ----------------------------------------------------------------------------
// sgb_pkg: shared types and constants for the 7-tap separable blur
// Holds the packed pixel type, the front-to-back item, and kernel helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package sgb_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 24;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int HIST_ROWS  = 6;
    localparam int ACC_W      = 14;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pix_t             vert;
    } item_t;

    // taps a..g, a oldest; weights 1,6,15,20,15,6,1
    function automatic logic [CH_W-1:0] blur7(
        input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] c, input logic [CH_W-1:0] d,
        input logic [CH_W-1:0] e, input logic [CH_W-1:0] f,
        input logic [CH_W-1:0] g);
        logic [ACC_W-1:0] acc;
        begin
            acc = ACC_W'(a) + ACC_W'(g)
                + ACC_W'(6) * (ACC_W'(b) + ACC_W'(f))
                + ACC_W'(15) * (ACC_W'(c) + ACC_W'(e))
                + ACC_W'(20) * ACC_W'(d);
            blur7 = acc[ACC_W-1:6];
        end
    endfunction

    function automatic pix_t blur7_pix(
        input pix_t a, input pix_t b, input pix_t c, input pix_t d,
        input pix_t e, input pix_t f, input pix_t g);
        pix_t r;
        begin
            for (int k = 0; k < 3; k++)
            begin
                r[k*CH_W +: CH_W] = blur7(a[k*CH_W +: CH_W], b[k*CH_W +: CH_W],
                    c[k*CH_W +: CH_W], d[k*CH_W +: CH_W], e[k*CH_W +: CH_W],
                    f[k*CH_W +: CH_W], g[k*CH_W +: CH_W]);
            end
            blur7_pix = r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/sgb_front.sv -----
// ----------------------------------------------------------------------------
// sgb_front: raster counters, line stores and vertical pass
// Stage 0 tracks row/column and reads six line stores; stage 1 filters.
// ----------------------------------------------------------------------------
`default_nettype none
module sgb_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  sgb_pkg::pix_t          in_pix,
    input  wire  [sgb_pkg::FW_W-1:0]     frame_width,
    input  wire  [sgb_pkg::FH_W-1:0]     frame_height,
    output logic                         item_valid,
    input  wire                          item_ready,
    output sgb_pkg::item_t               item
);
    import sgb_pkg::*;

    localparam int LIM = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int AW  = $clog2(LIM);

    pix_t mem0 [LIM];
    pix_t mem1 [LIM];
    pix_t mem2 [LIM];
    pix_t mem3 [LIM];
    pix_t mem4 [LIM];
    pix_t mem5 [LIM];

    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   col_reg;
    logic [2:0]       base_reg;
    logic [ROW_W:0]   row_next;
    logic [COL_W:0]   col_next;
    logic [2:0]       base_next;
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [ROW_W:0]   ri;
    logic [2:0]       bi;
    logic [COL_W:0]   cj;
    logic             adv;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [2:0]       s1_base_reg;
    pix_t             s1_px_reg;
    pix_t             rd_reg [HIST_ROWS];

    logic             o_valid_reg;
    item_t            o_reg;
    pix_t             tap [HIST_ROWS];
    logic [3:0]       slot;
    pix_t             vert;
    logic             s1_go;

    always_comb
    begin
        w = (frame_width < FW_W'(7)) ? FW_W'(7) : frame_width;
        if (w > FW_W'(LIM))
            w = FW_W'(LIM);
        h = (frame_height < FH_W'(7)) ? FH_W'(7) : frame_height;
        if (h > FH_W'(4096))
            h = FH_W'(4096);
        ri = {1'b0, row_reg};
        bi = base_reg;
        cj = col_reg;
        if (FW_W'(cj) >= w)
        begin
            cj = '0;
            ri = ri + 1'b1;
            bi = (bi == 3'd5) ? 3'd0 : bi + 3'd1;
        end
        if (FH_W'(ri) >= h)
        begin
            ri = '0;
            bi = '0;
        end
        col_next  = cj + 1'b1;
        row_next  = ri;
        base_next = bi;
        if (FW_W'(col_next) >= w)
        begin
            col_next  = '0;
            row_next  = ri + 1'b1;
            base_next = (bi == 3'd5) ? 3'd0 : bi + 3'd1;
            if (FH_W'(row_next) >= h)
            begin
                row_next  = '0;
                base_next = '0;
            end
        end
    end

    assign s1_go    = !o_valid_reg || item_ready;
    assign in_ready = !s1_valid_reg || s1_go;
    assign adv      = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg[0] <= mem0[cj[AW-1:0]];
            rd_reg[1] <= mem1[cj[AW-1:0]];
            rd_reg[2] <= mem2[cj[AW-1:0]];
            rd_reg[3] <= mem3[cj[AW-1:0]];
            rd_reg[4] <= mem4[cj[AW-1:0]];
            rd_reg[5] <= mem5[cj[AW-1:0]];
            case (bi)
                3'd0:    mem0[cj[AW-1:0]] <= in_pix;
                3'd1:    mem1[cj[AW-1:0]] <= in_pix;
                3'd2:    mem2[cj[AW-1:0]] <= in_pix;
                3'd3:    mem3[cj[AW-1:0]] <= in_pix;
                3'd4:    mem4[cj[AW-1:0]] <= in_pix;
                default: mem5[cj[AW-1:0]] <= in_pix;
            endcase
            s1_row_reg  <= ri[ROW_W-1:0];
            s1_col_reg  <= cj[COL_W-1:0];
            s1_base_reg <= bi;
            s1_px_reg   <= in_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                row_reg  <= row_next[ROW_W-1:0];
                col_reg  <= col_next;
                base_reg <= base_next;
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_go)
                o_valid_reg <= s1_valid_reg;
        end
    end

    // rotate so tap[0] is the oldest row (slot base)
    always_comb
    begin
        slot = '0;
        for (int t = 0; t < HIST_ROWS; t++)
        begin
            slot = {1'b0, s1_base_reg} + 4'(t);
            if (slot >= 4'd6)
                slot = slot - 4'd6;
            tap[t] = rd_reg[slot[2:0]];
        end
        vert = blur7_pix(tap[0], tap[1], tap[2], tap[3], tap[4], tap[5], s1_px_reg);
        if (s1_row_reg < ROW_W'(6))
            vert = '0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            o_reg.ok   <= (s1_row_reg >= ROW_W'(3)) && (s1_col_reg >= COL_W'(6));
            o_reg.row  <= s1_row_reg - ROW_W'(3);
            o_reg.col  <= s1_col_reg - COL_W'(3);
            o_reg.vert <= vert;
        end
    end

    assign item_valid = o_valid_reg;
    assign item       = o_reg;

endmodule
`default_nettype wire

// ----- sv/sgb_fifo.sv -----
// ----------------------------------------------------------------------------
// sgb_fifo: short queue between the vertical and horizontal passes
// Four-entry register queue with independent push and pop.
// ----------------------------------------------------------------------------
`default_nettype none
module sgb_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  wire  sgb_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output sgb_pkg::item_t      pop_item
);
    import sgb_pkg::*;

    item_t      q_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = cnt_reg != 3'd4;
    assign pop_valid  = cnt_reg != 3'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ----- sv/sgb_back.sv -----
// ----------------------------------------------------------------------------
// sgb_back: column window and horizontal pass
// Shifts vertical results through a six-word window and drives the output.
// ----------------------------------------------------------------------------
`default_nettype none
module sgb_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       item_valid,
    output logic                      item_ready,
    input  wire  sgb_pkg::item_t      item,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [sgb_pkg::ROW_W-1:0] out_row,
    output logic [sgb_pkg::COL_W-1:0] out_col,
    output sgb_pkg::pix_t             out_pix,
    output logic                      written
);
    import sgb_pkg::*;

    pix_t             win_reg [HIST_ROWS];
    logic             v_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    pix_t             pix_reg;
    logic             wr_reg;
    logic             take;
    pix_t             hz;

    assign item_ready = !v_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign hz = blur7_pix(win_reg[0], win_reg[1], win_reg[2], win_reg[3],
                          win_reg[4], win_reg[5], item.vert);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
            for (int t = 0; t < HIST_ROWS; t++)
            begin
                win_reg[t] <= '0;
            end
        end
        else
        begin
            if (item_ready)
                v_reg <= item_valid;
            if (take)
            begin
                for (int t = 0; t < HIST_ROWS - 1; t++)
                begin
                    win_reg[t] <= win_reg[t+1];
                end
                win_reg[HIST_ROWS-1] <= item.vert;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wr_reg  <= item.ok;
            row_reg <= item.ok ? item.row : '0;
            col_reg <= item.ok ? item.col : '0;
            pix_reg <= item.ok ? hz : '0;
        end
    end

    assign out_valid = v_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_pix   = pix_reg;
    assign written   = wr_reg;

endmodule
`default_nettype wire

// ----- sv/separable_gaussian_blur_7tap.sv -----
// ----------------------------------------------------------------------------
// separable_gaussian_blur_7tap: 7-tap binomial RGB blur over a raster stream
// Vertical pass over six line stores, queue, then horizontal pass.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   red, green, blue
//  m_axis    out  m_axis_tvalid/tready   row, col, rgb, written
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One pixel per clock unless the output stalls; line store ports set the
//  rate. Stages: line store read, vertical pass, queue, horizontal pass.
//  Reset clears counters, window and config (640 x 480); line stores are
//  not cleared. Each stage stalls on its own through valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
module separable_gaussian_blur_7tap #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row, out_col, red_out, green_out, blue_out, pad
    output logic        m_axis_tuser,   // written
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [12:0] cfg_data
);
    import sgb_pkg::*;

    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    pix_t             in_pix;
    logic             f_valid;
    logic             f_ready;
    item_t            f_item;
    logic             b_valid;
    logic             b_ready;
    item_t            b_item;
    logic [ROW_W-1:0] o_row;
    logic [COL_W-1:0] o_col;
    pix_t             o_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_W'(640);
            fh_reg <= FH_W'(480);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    // pack as blue low, red high
    assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    sgb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pix(in_pix),
        .frame_width(fw_reg), .frame_height(fh_reg),
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    sgb_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
        .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
    );

    sgb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_row(o_row), .out_col(o_col), .out_pix(o_pix), .written(m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, o_pix[7:0], o_pix[15:8], o_pix[23:16], o_col, o_row};

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream check of the 7-tap separable RGB blur
// Drives raster frames through the pixel stream with random idle and stall
// bursts. Each accepted pixel is run through a local line-store and window
// predictor, and every output word is checked against the oldest prediction.
// Frame sizes are changed between whole frames, extremes and clamped values
// included.
// ----------------------------------------------------------------------------
module testbench;
    import sgb_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_W        = 1024;

    typedef struct {
        logic [11:0] row;
        logic [9:0]  col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        written;
    } blur_out_t;

    class blur_scoreboard;
        logic [23:0] line_store [0:5][0:MAX_W-1];
        logic [23:0] vert_window [0:5];
        int          row_pos;
        int          col_pos;
        int          width_reg;
        int          height_reg;
        blur_out_t   expected_q [$];
        int          errors;

        function new();
            foreach (vert_window[k])
                vert_window[k] = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = 640;
            height_reg = 480;
            errors     = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [12:0] value);
            if (idx == REG_FRAME_WIDTH)
                width_reg = int'(value[10:0]);
            else
                height_reg = int'(value);
        endfunction

        function automatic logic [7:0] tap7(input int s [7]);
            int acc;
            acc = s[0] + s[6] + 6 * (s[1] + s[5]) + 15 * (s[2] + s[4]) + 20 * s[3];
            return 8'(acc >> 6);
        endfunction

        // pixel layout here: red [23:16], green [15:8], blue [7:0]
        function automatic logic [23:0] blur_pix(input logic [23:0] t [7]);
            logic [23:0] res;
            int          s [7];
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 7; k++)
                    s[k] = int'(t[k][c*8 +: 8]);
                res[c*8 +: 8] = tap7(s);
            end
            return res;
        endfunction

        function void note_pixel(logic [23:0] px);
            int          w;
            int          h;
            int          i;
            int          j;
            int          base;
            logic [23:0] taps [7];
            logic [23:0] vert;
            logic [23:0] res;
            blur_out_t   e;
            w = width_reg < 7 ? 7 : (width_reg > MAX_W ? MAX_W : width_reg);
            h = height_reg < 7 ? 7 : (height_reg > 4096 ? 4096 : height_reg);
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
                row_pos = 0;
            i = row_pos;
            j = col_pos;
            base = i % 6;
            if (i >= 6)
            begin
                for (int t = 0; t < 6; t++)
                    taps[t] = line_store[(base + t) % 6][j];
                taps[6] = px;
                vert = blur_pix(taps);
            end
            else
                vert = '0;
            line_store[base][j] = px;
            for (int t = 0; t < 6; t++)
                taps[t] = vert_window[t];
            taps[6] = vert;
            if (i >= 3 && j >= 6)
            begin
                res = blur_pix(taps);
                e.row     = 12'(i - 3);
                e.col     = 10'(j - 3);
                e.red     = res[23:16];
                e.green   = res[15:8];
                e.blue    = res[7:0];
                e.written = 1'b1;
            end
            else
            begin
                e.row = '0; e.col = '0; e.red = '0; e.green = '0; e.blue = '0;
                e.written = 1'b0;
            end
            expected_q.push_back(e);
            for (int t = 0; t < 5; t++)
                vert_window[t] = vert_window[t + 1];
            vert_window[5] = vert;
            col_pos = j + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = i + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void check_word(logic [47:0] data, logic user);
            blur_out_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word, expected none, actual %h/%b",
                    $time, data, user);
                return;
            end
            e = expected_q.pop_front();
            if (data[11:0] !== e.row)
            begin
                errors++;
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, data[11:0]);
            end
            if (data[21:12] !== e.col)
            begin
                errors++;
                $display("%0t: out_col expected %0d actual %0d", $time, e.col, data[21:12]);
            end
            if (data[29:22] !== e.red)
            begin
                errors++;
                $display("%0t: red_out expected %0d actual %0d", $time, e.red, data[29:22]);
            end
            if (data[37:30] !== e.green)
            begin
                errors++;
                $display("%0t: green_out expected %0d actual %0d",
                    $time, e.green, data[37:30]);
            end
            if (data[45:38] !== e.blue)
            begin
                errors++;
                $display("%0t: blue_out expected %0d actual %0d", $time, e.blue, data[45:38]);
            end
            if (user !== e.written)
            begin
                errors++;
                $display("%0t: written expected %0b actual %0b", $time, e.written, user);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    blur_scoreboard sb = new();
    bit             quiet = 1'b0;
    bit             noisy = 1'b1;
    int             cycles = 0;
    int             stall_left = 0;

    separable_gaussian_blur_7tap u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end

    // hold ready low for random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (quiet || !noisy)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic write_cfg(input logic [0:0] idx, input logic [12:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (!quiet && noisy && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {b, g, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pixel({r, g, b});
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.expected_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_frames(input logic [12:0] w_val, input logic [12:0] h_val,
                              input int frames);
        int w;
        int h;
        wait_idle();
        write_cfg(REG_FRAME_WIDTH, w_val);
        write_cfg(REG_FRAME_HEIGHT, h_val);
        w = sb.width_reg < 7 ? 7 : (sb.width_reg > MAX_W ? MAX_W : sb.width_reg);
        h = sb.height_reg < 7 ? 7 : (sb.height_reg > 4096 ? 4096 : sb.height_reg);
        for (int n = 0; n < frames * w * h; n++)
        begin
            if (n % 97 == 0)
                noisy = $urandom_range(0, 3) != 0;
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        logic [7:0] pick [6];
        int         random_items;
        pick = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // smallest frame with extreme channel values
        write_cfg(REG_FRAME_WIDTH, 13'd7);
        write_cfg(REG_FRAME_HEIGHT, 13'd7);
        for (int n = 0; n < 49; n++)
            send_pixel(pick[n % 6], pick[(n / 2) % 6], pick[(n / 3) % 6]);

        // clamped sizes: narrow width with high bits set, zero height
        run_frames(13'h1803, 13'd0, 1);

        random_items = 0;
        while (random_items < 1350)
        begin
            if (random_items > 1000)
                quiet = 1'b1;
            run_frames(13'($urandom_range(7, 24)), 13'($urandom_range(7, 12)), 1);
            random_items = random_items + sb.width_reg * sb.height_reg;
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/sgb_pkg.sv
sv/sgb_front.sv
sv/sgb_fifo.sv
sv/sgb_back.sv
sv/separable_gaussian_blur_7tap.sv
sim/testbench.sv
